@@ rtl/aabb_pkg.sv @@
// Shared types, constants and register map for the bounding box transform block.
// No dependencies; every module of the block imports it.
package aabb_pkg;

	localparam int COORD_WIDTH = 32;
	localparam int FRAC_BITS   = 16;
	localparam int AXES        = 3;
	localparam int FIELD_W     = 32;
	localparam int COEF_W      = 32;
	localparam int REG_W       = 64;
	localparam int REG_COUNT   = 6;
	localparam int CFG_IDX_W   = $clog2(REG_COUNT);

	// exact sum of three products plus the shifted translation
	localparam int PROD_W  = COEF_W + COORD_WIDTH;
	localparam int TERM_W  = (PROD_W > COEF_W + FRAC_BITS) ? PROD_W : COEF_W + FRAC_BITS;
	localparam int SUM_W   = TERM_W + 2;
	localparam int SHIFT_W = SUM_W - FRAC_BITS;

	localparam logic signed [SHIFT_W-1:0] LIM_HI =
		SHIFT_W'((66'sd1 <<< (COORD_WIDTH - 1)) - 66'sd1);
	localparam logic signed [SHIFT_W-1:0] LIM_LO = -LIM_HI - SHIFT_W'(1);

	typedef logic signed [COORD_WIDTH-1:0] coord_t;
	typedef logic signed [COEF_W-1:0]      coef_t;

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_LOAD  = 2'd1,
		CMD_MERGE = 2'd2,
		CMD_XFORM = 2'd3
	} cmd_e;

	localparam logic [CFG_IDX_W-1:0] REG_ROW0_XY = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_ROW0_ZT = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_ROW1_XY = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_ROW1_ZT = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_ROW2_XY = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] REG_ROW2_ZT = CFG_IDX_W'(5);

	// identity matrix, zero translation
	localparam logic [REG_W-1:0] RST_ROW0_XY = 64'd65536;
	localparam logic [REG_W-1:0] RST_ROW0_ZT = 64'd0;
	localparam logic [REG_W-1:0] RST_ROW1_XY = 64'd281474976710656;
	localparam logic [REG_W-1:0] RST_ROW1_ZT = 64'd0;
	localparam logic [REG_W-1:0] RST_ROW2_XY = 64'd0;
	localparam logic [REG_W-1:0] RST_ROW2_ZT = 64'd65536;

	typedef struct packed {
		coef_t ct;
		coef_t cz;
		coef_t cy;
		coef_t cx;
	} row_coef_t;

	typedef struct packed {
		coord_t [AXES-1:0] hi;
		coord_t [AXES-1:0] lo;
	} box_t;

	typedef struct packed {
		box_t box;
		logic is_empty;
		logic load_error;
		logic saturated;
	} res_t;

endpackage

@@ rtl/aabb_row_unit.sv @@
// One row of the affine map: bounds of that output axis over the stored box.
// Depends on aabb_pkg. Pure combinational logic.
module aabb_row_unit
	import aabb_pkg::*;
(
	input  row_coef_t         coef,
	input  coord_t [AXES-1:0] lo,
	input  coord_t [AXES-1:0] hi,
	output coord_t            row_min,
	output coord_t            row_max,
	output logic              sat
);

	coef_t                         c [AXES];
	logic signed [PROD_W-1:0]      p_lo [AXES];
	logic signed [PROD_W-1:0]      p_hi [AXES];
	logic signed [PROD_W-1:0]      p_min [AXES];
	logic signed [PROD_W-1:0]      p_max [AXES];
	logic signed [SUM_W-1:0]       t_term;
	logic signed [SUM_W-1:0]       sum_min;
	logic signed [SUM_W-1:0]       sum_max;
	logic signed [SUM_W-1:0]       sh_min_full;
	logic signed [SUM_W-1:0]       sh_max_full;
	logic signed [SHIFT_W-1:0]     sh_min;
	logic signed [SHIFT_W-1:0]     sh_max;

	assign c[0] = coef.cx;
	assign c[1] = coef.cy;
	assign c[2] = coef.cz;

	// linear in each axis: the smaller and larger product per axis bound all corners,
	// also for a copied box whose min lies above its max
	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			p_lo[a] = $signed(c[a]) * $signed(lo[a]);
			p_hi[a] = $signed(c[a]) * $signed(hi[a]);
			if (p_lo[a] < p_hi[a]) begin
				p_min[a] = p_lo[a];
				p_max[a] = p_hi[a];
			end else begin
				p_min[a] = p_hi[a];
				p_max[a] = p_lo[a];
			end
		end
	end

	assign t_term  = SUM_W'($signed(coef.ct)) <<< FRAC_BITS;
	assign sum_min = SUM_W'(p_min[0]) + SUM_W'(p_min[1]) + SUM_W'(p_min[2]) + t_term;
	assign sum_max = SUM_W'(p_max[0]) + SUM_W'(p_max[1]) + SUM_W'(p_max[2]) + t_term;

	// floor shift back to the coordinate format
	assign sh_min_full = sum_min >>> FRAC_BITS;
	assign sh_max_full = sum_max >>> FRAC_BITS;
	assign sh_min      = sh_min_full[SHIFT_W-1:0];
	assign sh_max      = sh_max_full[SHIFT_W-1:0];

	always_comb begin
		if (sh_min > LIM_HI)
			row_min = LIM_HI[COORD_WIDTH-1:0];
		else if (sh_min < LIM_LO)
			row_min = LIM_LO[COORD_WIDTH-1:0];
		else
			row_min = sh_min[COORD_WIDTH-1:0];

		if (sh_max > LIM_HI)
			row_max = LIM_HI[COORD_WIDTH-1:0];
		else if (sh_max < LIM_LO)
			row_max = LIM_LO[COORD_WIDTH-1:0];
		else
			row_max = sh_max[COORD_WIDTH-1:0];
	end

	// some corner clamps exactly when the extremes leave the range
	assign sat = (sh_max > LIM_HI) || (sh_min < LIM_LO);

endmodule

@@ rtl/aabb_box_core.sv @@
// Stored box and the command logic: clear, load, merge and affine transform.
// Depends on aabb_pkg and aabb_row_unit.
module aabb_box_core
	import aabb_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    adv,
	input  cmd_e                    cmd,
	input  box_t                    given,
	input  logic                    other_empty,
	input  row_coef_t [AXES-1:0]    matrix,
	output res_t                    res
);

	box_t               box_q;
	logic               empty_q;
	box_t               box_nxt;
	logic               empty_nxt;
	logic               load_err;
	logic               sat_any;
	coord_t [AXES-1:0]  x_min;
	coord_t [AXES-1:0]  x_max;
	logic   [AXES-1:0]  x_sat;

	for (genvar r = 0; r < AXES; r++) begin : g_row
		aabb_row_unit u_row (
			.coef    (matrix[r]),
			.lo      (box_q.lo),
			.hi      (box_q.hi),
			.row_min (x_min[r]),
			.row_max (x_max[r]),
			.sat     (x_sat[r])
		);
	end

	always_comb begin
		load_err = 1'b0;
		for (int a = 0; a < AXES; a++)
			if ($signed(given.lo[a]) > $signed(given.hi[a]))
				load_err = 1'b1;
	end

	always_comb begin
		box_nxt   = box_q;
		empty_nxt = empty_q;
		sat_any   = 1'b0;
		case (cmd)
			CMD_CLEAR: begin
				box_nxt   = '0;
				empty_nxt = 1'b1;
			end
			CMD_LOAD: begin
				if (load_err) begin
					box_nxt   = '0;
					empty_nxt = 1'b1;
				end else begin
					box_nxt   = given;
					empty_nxt = 1'b0;
				end
			end
			CMD_MERGE: begin
				if (!other_empty) begin
					for (int a = 0; a < AXES; a++) begin
						if (empty_q || $signed(given.lo[a]) < $signed(box_q.lo[a]))
							box_nxt.lo[a] = given.lo[a];
						if (empty_q || $signed(given.hi[a]) > $signed(box_q.hi[a]))
							box_nxt.hi[a] = given.hi[a];
					end
					empty_nxt = 1'b0;
				end
			end
			default: begin
				if (!empty_q) begin
					box_nxt.lo = x_min;
					box_nxt.hi = x_max;
					sat_any    = |x_sat;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_q   <= '0;
			empty_q <= 1'b1;
		end else if (adv) begin
			box_q   <= box_nxt;
			empty_q <= empty_nxt;
		end
	end

	assign res.box        = box_nxt;
	assign res.is_empty   = empty_nxt;
	assign res.load_error = (cmd == CMD_LOAD) && load_err;
	assign res.saturated  = sat_any;

endmodule

@@ rtl/aabb_transform_merge.sv @@
// Top level of the bounding box transform block: stream ports, input and result
// registers, matrix registers. Depends on aabb_pkg and aabb_box_core.

// One request enters per clock while the input register is free or advancing; a held
// result with m_axis_tready low stalls it. A request passes the input register, then
// the result register. The whole transform (six 32x32 multiplies per row, sum, shift
// and clamp) sits between the input register and the box and result registers, and
// the box is updated as each request advances. Requests are processed in order
// against one stored box; every request yields one result. Matrix registers
// are written through cfg_we/cfg_index/cfg_wdata and should change only while
// no request is in flight.
module aabb_transform_merge
	import aabb_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,

	input  logic                       cfg_we,
	input  logic [CFG_IDX_W-1:0]       cfg_index,
	input  logic [REG_W-1:0]           cfg_wdata,

	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	// min_x, min_y, min_z, max_x, max_y, max_z
	input  logic [6*FIELD_W-1:0]       s_axis_tdata,
	// command[1:0], other_empty[2]
	input  logic [2:0]                 s_axis_tuser,

	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	// box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
	output logic [6*FIELD_W-1:0]       m_axis_tdata,
	// is_empty[0], load_error[1], saturated[2]
	output logic [2:0]                 m_axis_tuser
);

	logic [REG_W-1:0]       cfg_q [REG_COUNT];
	row_coef_t [AXES-1:0]   matrix;

	logic                   valid_s1;
	cmd_e                   cmd_s1;
	box_t                   box_s1;
	logic                   oe_s1;
	logic                   valid_s2;
	res_t                   res_s2;
	res_t                   core_res;
	logic                   adv;
	box_t                   in_box;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q[0] <= RST_ROW0_XY;
			cfg_q[1] <= RST_ROW0_ZT;
			cfg_q[2] <= RST_ROW1_XY;
			cfg_q[3] <= RST_ROW1_ZT;
			cfg_q[4] <= RST_ROW2_XY;
			cfg_q[5] <= RST_ROW2_ZT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ROW0_XY: cfg_q[0] <= cfg_wdata;
				REG_ROW0_ZT: cfg_q[1] <= cfg_wdata;
				REG_ROW1_XY: cfg_q[2] <= cfg_wdata;
				REG_ROW1_ZT: cfg_q[3] <= cfg_wdata;
				REG_ROW2_XY: cfg_q[4] <= cfg_wdata;
				REG_ROW2_ZT: cfg_q[5] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		for (int r = 0; r < AXES; r++) begin
			matrix[r].cx = cfg_q[2*r][COEF_W-1:0];
			matrix[r].cy = cfg_q[2*r][REG_W-1:COEF_W];
			matrix[r].cz = cfg_q[2*r+1][COEF_W-1:0];
			matrix[r].ct = cfg_q[2*r+1][REG_W-1:COEF_W];
		end
	end

	// the low coordinate bits of each field are taken; with both widths at 32 that is the whole field
	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			in_box.lo[a] = s_axis_tdata[a*FIELD_W +: COORD_WIDTH];
			in_box.hi[a] = s_axis_tdata[(AXES+a)*FIELD_W +: COORD_WIDTH];
		end
	end

	assign adv           = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			cmd_s1 <= cmd_e'(s_axis_tuser[1:0]);
			oe_s1  <= s_axis_tuser[2];
			box_s1 <= in_box;
		end
	end

	aabb_box_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv),
		.cmd         (cmd_s1),
		.given       (box_s1),
		.other_empty (oe_s1),
		.matrix      (matrix),
		.res         (core_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv)
			res_s2 <= core_res;
	end

	assign m_axis_tvalid = valid_s2;

	always_comb begin
		for (int a = 0; a < AXES; a++) begin
			m_axis_tdata[a*FIELD_W +: FIELD_W]        = FIELD_W'(res_s2.box.lo[a]);
			m_axis_tdata[(AXES+a)*FIELD_W +: FIELD_W] = FIELD_W'(res_s2.box.hi[a]);
		end
	end

	assign m_axis_tuser = {res_s2.saturated, res_s2.load_error, res_s2.is_empty};

	a_clear_empties: assert property (@(posedge clk) disable iff (!arst_n)
		adv && cmd_s1 == CMD_CLEAR |=> res_s2.is_empty && !res_s2.load_error)
		else $error("clear did not leave an empty box");

	a_err_empty: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.load_error |-> res_s2.is_empty && !res_s2.saturated)
		else $error("rejected load left a non-empty box");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.is_empty |-> res_s2.box == '0)
		else $error("empty box with nonzero corners");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && valid_s2 && !m_axis_tready |-> !s_axis_tready && !adv)
		else $error("input taken while both stages are blocked");

endmodule
